// ===== hdl/mbrf_pkg.sv =====
// Package for the read-request framer: frame constants, byte positions and CRC step.
package mbrf_pkg;

  localparam int FRAME_LEN        = 36;
  localparam int MB_LEN           = 8;
  localparam int PAYLOAD_OVERHEAD = 15;
  localparam int PAYLOAD_LEN      = PAYLOAD_OVERHEAD + MB_LEN;
  localparam int IDX_W            = $clog2(FRAME_LEN);

  typedef logic [IDX_W-1:0] idx_t;

  localparam logic [7:0]  START_MARK   = 8'hA5;
  localparam logic [7:0]  END_MARK     = 8'h15;
  localparam logic [15:0] CTRL_REQUEST = 16'h4510;
  localparam logic [7:0]  TYPE_BYTE    = 8'h02;
  localparam logic [15:0] SENSOR_WORD  = 16'h0000;
  localparam logic [7:0]  FUNC_READ    = 8'h03;
  localparam logic [15:0] PLEN_WORD    = 16'(PAYLOAD_LEN);
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic [15:0] SEQ_INIT     = 16'h0001;

  // byte positions within the frame
  localparam idx_t POS_START    = idx_t'(0);
  localparam idx_t POS_LEN_LO   = idx_t'(1);
  localparam idx_t POS_LEN_HI   = idx_t'(2);
  localparam idx_t POS_CTRL_LO  = idx_t'(3);
  localparam idx_t POS_CTRL_HI  = idx_t'(4);
  localparam idx_t POS_SEQ_LO   = idx_t'(5);
  localparam idx_t POS_SEQ_HI   = idx_t'(6);
  localparam idx_t POS_SER_0    = idx_t'(7);
  localparam idx_t POS_SER_1    = idx_t'(8);
  localparam idx_t POS_SER_2    = idx_t'(9);
  localparam idx_t POS_SER_3    = idx_t'(10);
  localparam idx_t POS_TYPE     = idx_t'(11);
  localparam idx_t POS_SENS_LO  = idx_t'(12);
  localparam idx_t POS_SENS_HI  = idx_t'(13);
  localparam idx_t POS_MB_ADDR  = idx_t'(FRAME_LEN - MB_LEN - 2);
  localparam idx_t POS_MB_FUNC  = idx_t'(FRAME_LEN - MB_LEN - 1);
  localparam idx_t POS_MB_SR_HI = idx_t'(FRAME_LEN - MB_LEN);
  localparam idx_t POS_MB_SR_LO = idx_t'(FRAME_LEN - MB_LEN + 1);
  localparam idx_t POS_MB_CN_HI = idx_t'(FRAME_LEN - MB_LEN + 2);
  localparam idx_t POS_MB_CN_LO = idx_t'(FRAME_LEN - MB_LEN + 3);
  localparam idx_t POS_CRC_LO   = idx_t'(FRAME_LEN - 4);
  localparam idx_t POS_CRC_HI   = idx_t'(FRAME_LEN - 3);
  localparam idx_t POS_SUM      = idx_t'(FRAME_LEN - 2);
  localparam idx_t POS_END      = idx_t'(FRAME_LEN - 1);

  // one byte of CRC-16/MODBUS, reflected
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/modbus_read_request_framer.sv =====
// Read-holding-registers request framer: wraps a Modbus read in a 36-byte logger frame.
//
// Channels: request beats (slave_id, start_register, register_count) on
// in_valid/in_ready; frame bytes on out_valid/out_ready, last_byte high on
// the end byte; logger_serial written on cfg_valid/cfg_ready (always ready).
// A request is held in an input register, then moved into the framer, which
// sends one byte per cycle while out_ready is high. CRC-16 and the 8-bit sum
// are built byte by byte as the frame goes out, so no CRC is computed before
// the frame starts. When idle, the first byte is valid once the request has
// passed the input register into the framer. Frames go out back to back: the
// next request is taken into the input register while a frame is still going
// out, and its frame follows the end byte with no gap.
// Reset: no frame in flight, input register empty, serial 0, sequence 1.
// The sequence number goes into bytes 5 and 6 and steps (16-bit wrap) when
// the end byte is taken.
// Receiver stall: the current byte holds; a second request waits in the input
// register and in_ready drops until the framer can take it.
module modbus_read_request_framer
  import mbrf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  slave_id,
  input  logic [15:0] start_register,
  input  logic [15:0] register_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  frame_byte,
  output logic        last_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] logger_serial
);

  logic        a_valid;
  logic [7:0]  a_slave;
  logic [15:0] a_start;
  logic [15:0] a_count;

  logic        b_active;
  idx_t        idx;
  logic [7:0]  b_slave;
  logic [15:0] b_start;
  logic [15:0] b_count;
  logic [15:0] crc;
  logic [7:0]  sum;
  logic [31:0] serial;
  logic [15:0] seq;

  logic beat_out;
  logic frame_done;
  logic a_take;

  assign cfg_ready  = 1'b1;
  assign out_valid  = b_active;
  assign last_byte  = b_active && (idx == POS_END);
  assign beat_out   = b_active && out_ready;
  assign frame_done = beat_out && (idx == POS_END);
  assign a_take     = a_valid && (!b_active || frame_done);
  assign in_ready   = !a_valid || a_take;

  always_comb begin
    case (idx)
      POS_START:    frame_byte = START_MARK;
      POS_LEN_LO:   frame_byte = PLEN_WORD[7:0];
      POS_LEN_HI:   frame_byte = PLEN_WORD[15:8];
      POS_CTRL_LO:  frame_byte = CTRL_REQUEST[7:0];
      POS_CTRL_HI:  frame_byte = CTRL_REQUEST[15:8];
      POS_SEQ_LO:   frame_byte = seq[7:0];
      POS_SEQ_HI:   frame_byte = seq[15:8];
      POS_SER_0:    frame_byte = serial[7:0];
      POS_SER_1:    frame_byte = serial[15:8];
      POS_SER_2:    frame_byte = serial[23:16];
      POS_SER_3:    frame_byte = serial[31:24];
      POS_TYPE:     frame_byte = TYPE_BYTE;
      POS_SENS_LO:  frame_byte = SENSOR_WORD[7:0];
      POS_SENS_HI:  frame_byte = SENSOR_WORD[15:8];
      POS_MB_ADDR:  frame_byte = b_slave;
      POS_MB_FUNC:  frame_byte = FUNC_READ;
      POS_MB_SR_HI: frame_byte = b_start[15:8];
      POS_MB_SR_LO: frame_byte = b_start[7:0];
      POS_MB_CN_HI: frame_byte = b_count[15:8];
      POS_MB_CN_LO: frame_byte = b_count[7:0];
      POS_CRC_LO:   frame_byte = crc[7:0];
      POS_CRC_HI:   frame_byte = crc[15:8];
      POS_SUM:      frame_byte = sum;
      POS_END:      frame_byte = END_MARK;
      default:      frame_byte = 8'h00;
    endcase
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      a_valid <= 1'b1;
    end else if (a_take) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_slave <= slave_id;
      a_start <= start_register;
      a_count <= register_count;
    end
  end

  // config and sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      serial <= '0;
      seq    <= SEQ_INIT;
    end else begin
      if (cfg_valid && cfg_ready) begin
        serial <= logger_serial;
      end
      if (frame_done) begin
        seq <= seq + 16'd1;
      end
    end
  end

  // framer
  always_ff @(posedge clk) begin
    if (rst) begin
      b_active <= 1'b0;
      idx      <= POS_START;
    end else if (a_take) begin
      b_active <= 1'b1;
      idx      <= POS_START;
    end else if (frame_done) begin
      b_active <= 1'b0;
      idx      <= POS_START;
    end else if (beat_out) begin
      idx <= idx + idx_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (a_take) begin
      b_slave <= a_slave;
      b_start <= a_start;
      b_count <= a_count;
      crc     <= CRC_INIT;
      sum     <= 8'h00;
    end else if (beat_out) begin
      if (idx != POS_START && idx < POS_SUM) begin
        sum <= sum + frame_byte;
      end
      if (idx >= POS_MB_ADDR && idx < POS_CRC_LO) begin
        crc <= crc_byte(crc, frame_byte);
      end
    end
  end

`ifndef ASSERT_OFF
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    b_active |-> idx <= POS_END)
    else $error("frame index past end byte");

  a_idle_idx: assert property (@(posedge clk) disable iff (rst)
    !b_active |-> idx == POS_START)
    else $error("idle framer with nonzero index");

  a_take_ok: assert property (@(posedge clk) disable iff (rst)
    a_take |-> (!b_active || (idx == POS_END && out_ready)))
    else $error("request loaded over a frame in flight");

  a_seq_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_byte) |=> seq == $past(seq) + 16'd1)
    else $error("sequence number did not step after frame");

  a_in_held: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> a_valid || b_active)
    else $error("accepted request lost");
`endif

endmodule

// ===== dv/modbus_read_request_framer_test.sv =====
// Testbench for the read-request framer: directed table and random requests, checked byte by byte.
`timescale 1ns / 1ps

module modbus_read_request_framer_test;

  localparam int          FRAME_BYTES = 36;
  localparam logic [7:0]  SOF_BYTE    = 8'hA5;
  localparam logic [7:0]  EOF_BYTE    = 8'h15;
  localparam logic [15:0] PAYLOAD_LEN = 16'd23;
  localparam logic [15:0] CTRL_CODE   = 16'h4510;
  localparam logic [7:0]  FRAME_TYPE  = 8'h02;
  localparam logic [7:0]  FN_READ     = 8'h03;
  localparam logic [15:0] SEQ_START   = 16'h0001;
  localparam logic [15:0] CRC_SEED    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam int          NUM_DIR     = 13;
  localparam int          NUM_RAND    = 96;
  localparam int          HOLD_CYCLES = 400;
  localparam int          MAX_PRINTS  = 60;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  typedef struct packed {
    logic [7:0]  sid;
    logic [15:0] sreg;
    logic [15:0] cnt;
    logic        golden;
    logic [15:0] crc;
  } request_row_t;

  // golden CRCs are the textbook function-3 examples
  request_row_t dir_rows [NUM_DIR] = '{
    '{8'h01, 16'h0000, 16'h0001, 1'b1, 16'h0A84},
    '{8'h01, 16'h0000, 16'h000A, 1'b1, 16'hCDC5},
    '{8'h11, 16'h006B, 16'h0003, 1'b1, 16'h8776},
    '{8'h00, 16'h0000, 16'h0000, 1'b0, 16'h0000},
    '{8'hFF, 16'hFFFF, 16'hFFFF, 1'b0, 16'h0000},
    '{8'hFF, 16'h0000, 16'hFFFF, 1'b0, 16'h0000},
    '{8'h00, 16'hFFFF, 16'h0000, 1'b0, 16'h0000},
    '{8'hAA, 16'h5555, 16'hAAAA, 1'b0, 16'h0000},
    '{8'h55, 16'hAAAA, 16'h5555, 1'b0, 16'h0000},
    '{8'h80, 16'h8000, 16'h0001, 1'b0, 16'h0000},
    '{8'h01, 16'h0001, 16'h8000, 1'b0, 16'h0000},
    '{8'hF7, 16'h1234, 16'h007D, 1'b0, 16'h0000},
    '{8'h7F, 16'h7FFF, 16'h7FFF, 1'b0, 16'h0000}
  };

  logic        clk            = 1'b0;
  logic        rst            = 1'b1;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic [7:0]  slave_id       = '0;
  logic [15:0] start_register = '0;
  logic [15:0] register_count = '0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [7:0]  frame_byte;
  logic        last_byte;
  logic        cfg_valid      = 1'b0;
  logic        cfg_ready;
  logic [31:0] logger_serial  = '0;

  frame_beat_t pending_bytes [$];
  frame_beat_t got_exp;
  logic [15:0] seq_model    = SEQ_START;
  logic [31:0] serial_model = '0;
  int          n_errors     = 0;
  int          snd_idle_pct = 21;
  int          rcv_idle_pct = 65;
  logic        hold_go      = 1'b0;
  logic        hold_done    = 1'b0;
  int          hold_left    = 0;

  modbus_read_request_framer i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .slave_id       (slave_id),
    .start_register (start_register),
    .register_count (register_count),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .frame_byte     (frame_byte),
    .last_byte      (last_byte),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .logger_serial  (logger_serial)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("TIMEOUT at %0t, %0d bytes still pending", $time, pending_bytes.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (n_errors < MAX_PRINTS) begin
      $display("MISMATCH @%0t: %s", $time, msg);
    end
    n_errors++;
  endtask

  // CRC-16/MODBUS over address, function, start and count, first byte at the top
  function automatic logic [15:0] request_crc16(input logic [47:0] msg);
    logic [15:0] c;
    c = CRC_SEED;
    for (int i = 5; i >= 0; i--) begin
      c = c ^ {8'h00, msg[i*8 +: 8]};
      for (int b = 0; b < 8; b++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
    end
    return c;
  endfunction

  function automatic void predict_frame(input logic [7:0] sid, input logic [15:0] sreg,
                                        input logic [15:0] cnt);
    logic [7:0]  fr [FRAME_BYTES];
    logic [15:0] crc;
    logic [7:0]  sum;
    crc    = request_crc16({sid, FN_READ, sreg, cnt});
    fr[0]  = SOF_BYTE;
    fr[1]  = PAYLOAD_LEN[7:0];
    fr[2]  = PAYLOAD_LEN[15:8];
    fr[3]  = CTRL_CODE[7:0];
    fr[4]  = CTRL_CODE[15:8];
    fr[5]  = seq_model[7:0];
    fr[6]  = seq_model[15:8];
    fr[7]  = serial_model[7:0];
    fr[8]  = serial_model[15:8];
    fr[9]  = serial_model[23:16];
    fr[10] = serial_model[31:24];
    fr[11] = FRAME_TYPE;
    for (int i = 12; i < 26; i++) begin
      fr[i] = 8'h00;
    end
    fr[26] = sid;
    fr[27] = FN_READ;
    fr[28] = sreg[15:8];
    fr[29] = sreg[7:0];
    fr[30] = cnt[15:8];
    fr[31] = cnt[7:0];
    fr[32] = crc[7:0];
    fr[33] = crc[15:8];
    sum = 8'h00;
    for (int i = 1; i < 34; i++) begin
      sum = sum + fr[i];
    end
    fr[34] = sum;
    fr[35] = EOF_BYTE;
    for (int i = 0; i < FRAME_BYTES; i++) begin
      pending_bytes.push_back('{data: fr[i], last: (i == FRAME_BYTES - 1)});
    end
    seq_model = seq_model + 16'd1;
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h last %b", frame_byte, last_byte));
        end else begin
          got_exp = pending_bytes.pop_front();
          if (frame_byte !== got_exp.data) begin
            report_mismatch($sformatf("frame_byte %02h, want %02h (%0d left)",
                                      frame_byte, got_exp.data, pending_bytes.size()));
          end
          if (last_byte !== got_exp.last) begin
            report_mismatch($sformatf("last_byte %b, want %b on byte %02h",
                                      last_byte, got_exp.last, got_exp.data));
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_frame(slave_id, start_register, register_count);
      end
      if (cfg_valid && cfg_ready) begin
        serial_model = logger_serial;
      end
    end
  end

  // receiver: random stalls plus one long hold-off to back the block up
  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  function automatic logic [7:0] pick8();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_request(input logic [7:0] sid, input logic [15:0] sreg,
                              input logic [15:0] cnt);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    slave_id       <= sid;
    start_register <= sreg;
    register_count <= cnt;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
  endtask

  task automatic drain_frames();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_serial(input logic [31:0] value);
    cfg_valid     <= 1'b1;
    logger_serial <= value;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_request(pick8(), pick16(), pick16());
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, serial still at its reset value
    for (int i = 0; i < NUM_DIR; i++) begin
      if (dir_rows[i].golden &&
          request_crc16({dir_rows[i].sid, FN_READ, dir_rows[i].sreg, dir_rows[i].cnt})
            !== dir_rows[i].crc) begin
        report_mismatch($sformatf("row %0d: CRC table entry %04h disagrees", i,
                                  dir_rows[i].crc));
      end
      send_request(dir_rows[i].sid, dir_rows[i].sreg, dir_rows[i].cnt);
    end
    drain_frames();

    write_serial(32'hFFFF_FFFF);
    send_random(NUM_RAND);
    drain_frames();

    snd_idle_pct = 65;
    rcv_idle_pct = 21;
    write_serial($urandom);
    send_random(NUM_RAND);
    drain_frames();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    write_serial(32'h0000_0000);
    hold_go = 1'b1;
    send_random(NUM_RAND);
    drain_frames();

    repeat (10) @(posedge clk);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
